>>> rtl/core/stpc_pkg.sv
`default_nettype none
package stpc_pkg;

   localparam int RawWidth = 20;
   localparam int WordWidth = 32;
   localparam int CsrDataWidth = 64;
   localparam int CsrIndexWidth = 2;
   localparam int QueueDepth = 4;
   localparam int QueueIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] RegTempCoeffs = 2'd0;
   localparam logic [CsrIndexWidth-1:0] RegPressCoeffsA = 2'd1;
   localparam logic [CsrIndexWidth-1:0] RegPressCoeffsB = 2'd2;
   localparam logic [CsrIndexWidth-1:0] RegPressCoeffNine = 2'd3;

   localparam logic [31:0] PressOffset = 32'd64000;
   localparam logic [31:0] PressBase = 32'd32768;
   localparam logic [31:0] PressFull = 32'd1048576;
   localparam logic [31:0] PressScale = 32'd3125;
   localparam logic [31:0] TempRound = 32'd128;
   localparam logic [31:0] SignBit = 32'h80000000;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } coeff_type;

   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] fine;
      logic [31:0] numer;
      logic [31:0] divisor;
      logic        post_double;
      logic        valid;
   } front_item_type;

   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] fine;
      logic [31:0] pressure;
      logic        valid;
   } result_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] mul32(input logic [31:0] x, input logic [31:0] y);
      logic [63:0] full;
      full = x * y;
      return full[31:0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/stpc_front.sv
`default_nettype none
module stpc_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire stpc_pkg::coeff_type  coeffs,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [19:0]          raw_t,
   input  wire logic [19:0]          raw_p,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output stpc_pkg::front_item_type  out_item
);
   localparam int Stages = 9;

   logic [Stages-1:0] vld_ff;
   logic              adv;
   logic [31:0] s1_ta_ff, s1_d_ff, s1_t2_ff;
   logic [19:0] s1_rp_ff;
   logic [31:0] s2_ta_ff, s2_dd_ff;
   logic [19:0] s2_rp_ff;
   logic [31:0] s3_ta_ff, s3_tb_ff;
   logic [19:0] s3_rp_ff;
   logic [31:0] s4_fine_ff, s4_a_ff, s4_d_ff;
   logic [19:0] s4_rp_ff;
   logic [31:0] s5_fine_ff, s5_temp_ff, s5_dd_ff, s5_ap5_ff, s5_ap2_ff;
   logic [19:0] s5_rp_ff;
   logic [31:0] s6_fine_ff, s6_temp_ff, s6_b6_ff, s6_ap5_ff, s6_p3d_ff, s6_ap2_ff;
   logic [19:0] s6_rp_ff;
   logic [31:0] s7_fine_ff, s7_temp_ff, s7_b_ff, s7_a_ff;
   logic [19:0] s7_rp_ff;
   logic [31:0] s8_fine_ff, s8_temp_ff, s8_b_ff, s8_div_ff;
   logic [19:0] s8_rp_ff;
   logic [31:0] s9_fine_ff, s9_temp_ff, s9_numer_ff, s9_div_ff;
   logic        s9_dbl_ff;

   logic [31:0] c_t1, c_ta, c_d, c_fine_in, c_a_in, c_b_in, c_p;

   assign adv = ~vld_ff[Stages-1] | out_ready;
   assign in_ready = adv;
   assign out_valid = vld_ff[Stages-1];
   assign c_t1 = {16'd0, coeffs.t1};
   assign c_ta = {15'd0, raw_t[19:3]} - {c_t1[30:0], 1'b0};
   assign c_d = {16'd0, raw_t[19:4]} - c_t1;
   assign c_fine_in = s3_ta_ff + s3_tb_ff;
   assign c_a_in = $signed(c_fine_in) >>> 1;
   assign c_b_in = s6_b6_ff + {s6_ap5_ff[30:0], 1'b0};
   assign c_p = stpc_pkg::mul32((stpc_pkg::PressFull - {12'd0, s8_rp_ff})
                                - $unsigned($signed(s8_b_ff) >>> 12),
                                stpc_pkg::PressScale);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Stages-2:0], in_valid};
      end
      if (adv) begin
         s1_ta_ff <= c_ta;
         s1_d_ff <= c_d;
         s1_t2_ff <= stpc_pkg::sx16(coeffs.t2);
         s1_rp_ff <= raw_p;
         s2_ta_ff <= $signed(stpc_pkg::mul32(s1_ta_ff, s1_t2_ff)) >>> 11;
         s2_dd_ff <= $signed(stpc_pkg::mul32(s1_d_ff, s1_d_ff)) >>> 12;
         s2_rp_ff <= s1_rp_ff;
         s3_ta_ff <= s2_ta_ff;
         s3_tb_ff <= $signed(stpc_pkg::mul32(s2_dd_ff, stpc_pkg::sx16(coeffs.t3))) >>> 14;
         s3_rp_ff <= s2_rp_ff;
         s4_fine_ff <= c_fine_in;
         s4_a_ff <= c_a_in - stpc_pkg::PressOffset;
         s4_d_ff <= $signed(c_a_in - stpc_pkg::PressOffset) >>> 2;
         s4_rp_ff <= s3_rp_ff;
         s5_fine_ff <= s4_fine_ff;
         s5_temp_ff <= $signed(stpc_pkg::mul32(s4_fine_ff, 32'd5) + stpc_pkg::TempRound) >>> 8;
         s5_dd_ff <= stpc_pkg::mul32(s4_d_ff, s4_d_ff);
         s5_ap5_ff <= stpc_pkg::mul32(s4_a_ff, stpc_pkg::sx16(coeffs.p5));
         s5_ap2_ff <= $signed(stpc_pkg::mul32(s4_a_ff, stpc_pkg::sx16(coeffs.p2))) >>> 1;
         s5_rp_ff <= s4_rp_ff;
         s6_fine_ff <= s5_fine_ff;
         s6_temp_ff <= s5_temp_ff;
         s6_b6_ff <= stpc_pkg::mul32($signed(s5_dd_ff) >>> 11, stpc_pkg::sx16(coeffs.p6));
         s6_ap5_ff <= s5_ap5_ff;
         s6_p3d_ff <= $signed(stpc_pkg::mul32(stpc_pkg::sx16(coeffs.p3),
                                               $signed(s5_dd_ff) >>> 13)) >>> 3;
         s6_ap2_ff <= s5_ap2_ff;
         s6_rp_ff <= s5_rp_ff;
         s7_fine_ff <= s6_fine_ff;
         s7_temp_ff <= s6_temp_ff;
         s7_b_ff <= $unsigned($signed(c_b_in) >>> 2) + {coeffs.p4, 16'd0};
         s7_a_ff <= $signed(s6_p3d_ff + s6_ap2_ff) >>> 18;
         s7_rp_ff <= s6_rp_ff;
         s8_fine_ff <= s7_fine_ff;
         s8_temp_ff <= s7_temp_ff;
         s8_b_ff <= s7_b_ff;
         s8_div_ff <= $signed(stpc_pkg::mul32(stpc_pkg::PressBase + s7_a_ff,
                                               {16'd0, coeffs.p1})) >>> 15;
         s8_rp_ff <= s7_rp_ff;
         s9_fine_ff <= s8_fine_ff;
         s9_temp_ff <= s8_temp_ff;
         s9_div_ff <= s8_div_ff;
         s9_dbl_ff <= c_p >= stpc_pkg::SignBit;
         s9_numer_ff <= (c_p >= stpc_pkg::SignBit) ? c_p : {c_p[30:0], 1'b0};
      end
   end

   always_comb begin
      out_item.temp = s9_temp_ff;
      out_item.fine = s9_fine_ff;
      out_item.numer = s9_numer_ff;
      out_item.divisor = s9_div_ff;
      out_item.post_double = s9_dbl_ff;
      out_item.valid = s9_div_ff != '0;
   end
endmodule
`default_nettype wire

>>> rtl/core/stpc_queue.sv
`default_nettype none
module stpc_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire stpc_pkg::front_item_type in_item,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output stpc_pkg::front_item_type  out_item
);
   localparam logic [stpc_pkg::QueueIndexWidth:0] CntFull =
      (stpc_pkg::QueueIndexWidth+1)'(stpc_pkg::QueueDepth);

   stpc_pkg::front_item_type mem_ff [stpc_pkg::QueueDepth];
   logic [stpc_pkg::QueueIndexWidth-1:0] wr_ff, rd_ff;
   logic [stpc_pkg::QueueIndexWidth:0] cnt_ff;
   logic push, pop;

   assign in_ready = cnt_ff != CntFull;
   assign out_valid = cnt_ff != '0;
   assign push = in_valid & in_ready;
   assign pop = out_valid & out_ready;
   assign out_item = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (stpc_pkg::QueueIndexWidth+1)'(push)
                   - (stpc_pkg::QueueIndexWidth+1)'(pop);
      end
      if (push) mem_ff[wr_ff] <= in_item;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntFull) else $error("queue overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || cnt_ff == CntFull) |-> wr_ff == rd_ff)
      else $error("queue pointers disagree");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> cnt_ff == $past(cnt_ff) - 1'b1) else $error("pop lost");
endmodule
`default_nettype wire

>>> rtl/core/stpc_back.sv
`default_nettype none
module stpc_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire stpc_pkg::coeff_type  coeffs,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire stpc_pkg::front_item_type in_item,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output stpc_pkg::result_type      out_item
);
   localparam int Steps = 32;
   localparam int Lat = Steps + 5;

   logic [Lat-1:0] vld_ff;
   logic adv;
   logic [31:0] rem_ff [Steps+1];
   logic [31:0] quo_ff [Steps+1];
   logic [31:0] dvs_ff [Steps+1];
   stpc_pkg::result_type carry_ff [Steps+1];
   logic dbl_ff [Steps+1];

   logic [31:0] p_ff, temp_a_ff, ab_ff, pb_ff;
   logic [31:0] pe_ff, pf_ff, pg_ff;
   stpc_pkg::result_type ra_ff, rb_ff, rc_ff;
   logic [31:0] p_div, p3;

   assign adv = ~vld_ff[Lat-1] | out_ready;
   assign in_ready = adv;
   assign out_valid = vld_ff[Lat-1];

   always_comb begin
      p_div = dbl_ff[Steps] ? {quo_ff[Steps][30:0], 1'b0} : quo_ff[Steps];
      if (!carry_ff[Steps].valid) p_div = '0;
      p3 = {3'd0, p_ff[31:3]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Lat-2:0], in_valid};
      end
      if (adv) begin
         rem_ff[0] <= '0;
         quo_ff[0] <= in_item.numer;
         dvs_ff[0] <= in_item.divisor;
         dbl_ff[0] <= in_item.post_double;
         carry_ff[0] <= '{temp: in_item.temp, fine: in_item.fine, pressure: '0,
                          valid: in_item.valid};
         for (int i = 0; i < Steps; i++) begin
            logic [32:0] trial;
            trial = {rem_ff[i], quo_ff[i][31]} - {1'b0, dvs_ff[i]};
            if (!trial[32]) begin
               rem_ff[i+1] <= trial[31:0];
               quo_ff[i+1] <= {quo_ff[i][30:0], 1'b1};
            end else begin
               rem_ff[i+1] <= {rem_ff[i][30:0], quo_ff[i][31]};
               quo_ff[i+1] <= {quo_ff[i][30:0], 1'b0};
            end
            dvs_ff[i+1] <= dvs_ff[i];
            dbl_ff[i+1] <= dbl_ff[i];
            carry_ff[i+1] <= carry_ff[i];
         end
         p_ff <= p_div;
         ra_ff <= carry_ff[Steps];
         temp_a_ff <= stpc_pkg::mul32(p3, p3);
         pb_ff <= $signed(stpc_pkg::mul32({2'd0, p_ff[31:2]}, stpc_pkg::sx16(coeffs.p8)))
                  >>> 13;
         pe_ff <= p_ff;
         rb_ff <= ra_ff;
         ab_ff <= $signed(stpc_pkg::mul32(stpc_pkg::sx16(coeffs.p9),
                                           {13'd0, temp_a_ff[31:13]})) >>> 12;
         pf_ff <= pb_ff;
         pg_ff <= pe_ff;
         rc_ff <= rb_ff;
         out_item.temp <= rc_ff.temp;
         out_item.fine <= rc_ff.fine;
         out_item.valid <= rc_ff.valid;
         out_item.pressure <= rc_ff.valid ?
            pg_ff + $unsigned($signed(ab_ff + pf_ff + stpc_pkg::sx16(coeffs.p7)) >>> 4)
            : '0;
      end
   end

   a_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_item.valid |-> out_item.pressure == '0)
      else $error("pressure not cleared");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("result dropped");
   a_stable: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> $stable(out_item)) else $error("result changed");
endmodule
`default_nettype wire

>>> rtl/core/sensor_temp_pressure_compensation.sv
// channel   dir  payload
// req_      in   tdata: raw_temperature[19:0], raw_pressure[39:20]
// rsp_      out  tdata: temperature_centi, fine_temperature, pressure_pa; tuser: pressure_valid
// csr_      in   index 0..3, 64-bit data
// One item per cycle sustained while rsp_ is not stalled; 9 front stages, a 4-entry queue,
// 1 divider load, 32 divider stages, 4 tail.
// The restoring divider pipeline, one quotient bit per stage, sets the latency.
// Synchronous reset clears valid flags and coefficients.
// A stalled rsp_ side holds the back pipe; the queue lets the front run on until it fills.
`default_nettype none
module sensor_temp_pressure_compensation (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // raw_temperature, raw_pressure
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,   // temperature_centi, fine_temperature, pressure_pa
   output logic             rsp_tuser,   // pressure_valid
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   stpc_pkg::coeff_type coeffs_ff;
   stpc_pkg::front_item_type f_item, q_item;
   stpc_pkg::result_type res;
   logic f_valid, f_ready, q_valid, q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeffs_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            stpc_pkg::RegTempCoeffs: begin
               coeffs_ff.t1 <= csr_wdata[15:0];
               coeffs_ff.t2 <= csr_wdata[31:16];
               coeffs_ff.t3 <= csr_wdata[47:32];
            end
            stpc_pkg::RegPressCoeffsA: begin
               coeffs_ff.p1 <= csr_wdata[15:0];
               coeffs_ff.p2 <= csr_wdata[31:16];
               coeffs_ff.p3 <= csr_wdata[47:32];
               coeffs_ff.p4 <= csr_wdata[63:48];
            end
            stpc_pkg::RegPressCoeffsB: begin
               coeffs_ff.p5 <= csr_wdata[15:0];
               coeffs_ff.p6 <= csr_wdata[31:16];
               coeffs_ff.p7 <= csr_wdata[47:32];
               coeffs_ff.p8 <= csr_wdata[63:48];
            end
            stpc_pkg::RegPressCoeffNine: coeffs_ff.p9 <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   stpc_front u_front (
      .clock(clock), .reset(reset), .coeffs(coeffs_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .raw_t(req_tdata[19:0]), .raw_p(req_tdata[39:20]),
      .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
   );

   stpc_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   stpc_back u_back (
      .clock(clock), .reset(reset), .coeffs(coeffs_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_item(res)
   );

   assign rsp_tdata = {res.pressure, res.fine, res.temp};
   assign rsp_tuser = res.valid;
endmodule
`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] temp_centi;
      logic [31:0] fine_temp;
      logic [31:0] press_pa;
      logic        press_valid;
   } comp_result_type;

   class comp_scoreboard;
      logic [47:0] temp_coeffs;
      logic [63:0] press_a;
      logic [63:0] press_b;
      logic [15:0] press_nine;
      comp_result_type pending[$];
      int errors;

      function new();
         temp_coeffs = '0;
         press_a = '0;
         press_b = '0;
         press_nine = '0;
         errors = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [63:0] value);
         case (idx)
            stpc_pkg::RegTempCoeffs: temp_coeffs = value[47:0];
            stpc_pkg::RegPressCoeffsA: press_a = value;
            stpc_pkg::RegPressCoeffsB: press_b = value;
            stpc_pkg::RegPressCoeffNine: press_nine = value[15:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] asr(logic [31:0] x, int n);
         return $unsigned($signed(x) >>> n);
      endfunction

      function logic [31:0] sext(logic [15:0] v);
         return {{16{v[15]}}, v};
      endfunction

      function comp_result_type compensate(logic [19:0] raw_t, logic [19:0] raw_p);
         comp_result_type r;
         logic [31:0] rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
         logic [31:0] a, b, d, fine, p;
         rt = {12'd0, raw_t};
         rp = {12'd0, raw_p};
         t1 = {16'd0, temp_coeffs[15:0]};
         t2 = sext(temp_coeffs[31:16]);
         t3 = sext(temp_coeffs[47:32]);
         p1 = {16'd0, press_a[15:0]};
         p2 = sext(press_a[31:16]);
         p3 = sext(press_a[47:32]);
         p4 = sext(press_a[63:48]);
         p5 = sext(press_b[15:0]);
         p6 = sext(press_b[31:16]);
         p7 = sext(press_b[47:32]);
         p8 = sext(press_b[63:48]);
         p9 = sext(press_nine);
         a = asr(((rt >> 3) - (t1 << 1)) * t2, 11);
         d = (rt >> 4) - t1;
         b = asr(asr(d * d, 12) * t3, 14);
         fine = a + b;
         r.fine_temp = fine;
         r.temp_centi = asr(fine * 32'd5 + 32'd128, 8);
         a = asr(fine, 1) - 32'd64000;
         d = asr(a, 2);
         b = asr(d * d, 11) * p6;
         b = b + ((a * p5) << 1);
         b = asr(b, 2) + (p4 << 16);
         a = asr(asr(p3 * asr(d * d, 13), 3) + asr(p2 * a, 1), 18);
         a = asr((32'd32768 + a) * p1, 15);
         r.press_valid = 1'b1;
         if (a == 0) begin
            p = 0;
            r.press_valid = 1'b0;
         end else begin
            p = ((32'd1048576 - rp) - asr(b, 12)) * 32'd3125;
            if (p < 32'h80000000) p = (p << 1) / a;
            else p = (p / a) * 32'd2;
            a = asr(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            b = asr((p >> 2) * p8, 13);
            p = p + asr(a + b + p7, 4);
         end
         r.press_pa = p;
         return r;
      endfunction

      function void note_input(logic [39:0] data);
         pending.push_back(compensate(data[19:0], data[39:20]));
      endfunction

      function void check_result(logic [95:0] data, logic flag);
         comp_result_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected item %h %b", $time, data, flag);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (data[31:0] !== e.temp_centi) begin
            $display("%0t temperature exp %h got %h", $time, e.temp_centi, data[31:0]);
            errors++;
         end
         if (data[63:32] !== e.fine_temp) begin
            $display("%0t fine exp %h got %h", $time, e.fine_temp, data[63:32]);
            errors++;
         end
         if (data[95:64] !== e.press_pa) begin
            $display("%0t pressure exp %h got %h", $time, e.press_pa, data[95:64]);
            errors++;
         end
         if (flag !== e.press_valid) begin
            $display("%0t valid exp %b got %b", $time, e.press_valid, flag);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 0;
   logic [1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   longint cycle_count = 0;
   comp_scoreboard board = new();

   sensor_temp_pressure_compensation i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && req_tvalid && req_tready) board.note_input(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
   end

   always @(negedge clock) begin
      rsp_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_item(logic [19:0] raw_t, logic [19:0] raw_p);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {raw_p, raw_t};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [63:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      board.set_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic load_coeffs(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
                              logic [15:0] p9);
      write_reg(stpc_pkg::RegTempCoeffs, {16'd0, tc});
      write_reg(stpc_pkg::RegPressCoeffsA, pa);
      write_reg(stpc_pkg::RegPressCoeffsB, pb);
      write_reg(stpc_pkg::RegPressCoeffNine, {48'd0, p9});
      csr_we <= 1'b0;
   endtask

   task automatic load_typical();
      logic [15:0] t1, p1;
      t1 = 16'd27504 + 16'($urandom_range(2000)) - 16'd1000;
      p1 = 16'd36477 + 16'($urandom_range(4000)) - 16'd2000;
      load_coeffs({16'hFC18 + 16'($urandom_range(15)), 16'd26435, t1},
                  {16'd2855, 16'hD0F8 + 16'($urandom_range(31)), 16'hD5D0, p1},
                  {16'hFFF9, 16'd15500, 16'hFFF9, 16'd140},
                  16'd6000 + 16'($urandom_range(200)));
   endtask

   task automatic random_phase(int count, bit realistic);
      for (int i = 0; i < count; i++) begin
         if (realistic && $urandom_range(9) != 0)
            send_item(20'd519888 + 20'($urandom_range(100000)) - 20'd50000,
                      20'd415148 + 20'($urandom_range(200000)) - 20'd100000);
         else
            send_item(20'($urandom), 20'($urandom));
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_item(20'd0, 20'd0);
      send_item(20'hFFFFF, 20'hFFFFF);
      drain();
      load_typical();
      send_item(20'd519888, 20'd415148);
      send_item(20'd0, 20'hFFFFF);
      send_item(20'hFFFFF, 20'd0);
      send_item(20'hAAAAA, 20'h55555);
      send_item(20'h55555, 20'hAAAAA);
      drain();
      load_coeffs(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  16'hFFFF);
      send_item(20'd0, 20'd0);
      send_item(20'hFFFFF, 20'hFFFFF);
      send_item(20'h12345, 20'h6789A);
      drain();
      load_coeffs(48'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000,
                  16'h8000);
      send_item(20'd0, 20'hFFFFF);
      send_item(20'hFFFFF, 20'd0);
      drain();
      load_coeffs(48'h7FFF_7FFF_0000, 64'h7FFF_7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_7FFF,
                  16'h7FFF);
      send_item(20'd0, 20'd0);
      send_item(20'hFFFFF, 20'hFFFFF);
      drain();

      send_idle_pct = 33;
      recv_idle_pct = 81;
      load_typical();
      random_phase(150, 1);
      drain();
      load_coeffs(48'($urandom) ^ {$urandom, 16'd0}, {$urandom, $urandom},
                  {$urandom, $urandom}, 16'($urandom));
      random_phase(100, 0);
      drain();
      send_idle_pct = 81;
      recv_idle_pct = 33;
      load_typical();
      random_phase(150, 1);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_coeffs(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                  16'($urandom));
      random_phase(100, 0);
      drain();
      load_typical();
      random_phase(230, 1);
      drain();
      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> files.f
rtl/core/stpc_pkg.sv
rtl/core/stpc_front.sv
rtl/core/stpc_queue.sv
rtl/core/stpc_back.sv
rtl/core/sensor_temp_pressure_compensation.sv
sim/tb_top.sv
